// ----- rtl/core/linear_blend_skinning_sparse_assert.svh -----
// Assertion macros shared by the skinning block.
`ifndef LINEAR_BLEND_SKINNING_SPARSE_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_SPARSE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LBSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lbss_pkg.sv -----
package lbss_pkg;

  localparam int MAT_WORDS     = 12;
  localparam int MARK_ENTRY    = 12;
  localparam int LANES_CARRIED = 4;
  localparam int ACC_W         = 50;
  localparam int TOT_W         = 17;

  localparam logic [1:0] OP_LOAD      = 2'd0;
  localparam logic [1:0] OP_SKIN      = 2'd1;
  localparam logic [1:0] OP_SKIN_LAST = 2'd2;
  localparam logic [1:0] OP_IGNORED   = 2'd3;

  localparam logic CFG_BONES_USED = 1'b0;
  localparam logic CFG_REUSE      = 1'b1;

  typedef struct packed {
    logic        vld;
    logic [1:0]  row;
    logic [1:0]  k;
    logic [15:0] w;
  } lbss_tag_t;

endpackage

// ----- rtl/core/linear_blend_skinning_sparse.sv -----
// Skinning of one vertex per beat from up to four bone influences.
// The input channel (in_valid/in_stall) carries load beats and skin beats.
// A load beat writes one matrix word or one affected mark if its address is in
// range; it produces no result. A skin beat produces exactly one result beat.
// The user must write the configuration port only while the block is idle;
// the block itself does not enforce it. A skin beat visits each lane in turn,
// fetches the matrix words of each valid influence through the single read
// port of the store, and then drains the transform pipeline. A bit-serial
// division by the weight total follows, and then the result register is
// loaded; only then is the next beat taken. Pass-through and bind copies
// skip the division.
// The result sits in an output register, so the block takes the next beat
// while a result waits; a further result waits until the register is free,
// and in_stall is high meanwhile.
// Reset clears the batch tally, sets bones-used to one and reuse off at once;
// the affected marks are then cleared one per cycle, one mark per bone, with
// in_stall high. The matrix store is not cleared and must be loaded before
// the bones it holds are used.
module linear_blend_skinning_sparse import lbss_pkg::*; #(
  parameter int MAX_BONES  = 64,
  parameter int INFLUENCES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [9:0]         in_load_address,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_bind_x,
  input  logic signed [31:0] in_bind_y,
  input  logic signed [31:0] in_bind_z,
  input  logic [31:0]        in_bone_ids_packed,
  input  logic [63:0]        in_weights_packed,
  input  logic signed [31:0] in_prev_x,
  input  logic signed [31:0] in_prev_y,
  input  logic signed [31:0] in_prev_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_recomputed,
  output logic [31:0]        out_updated_count,
  output logic               out_batch_end
);

  localparam int NL  = (INFLUENCES < LANES_CARRIED) ? INFLUENCES : LANES_CARRIED;
  localparam int SAW = $clog2(MAX_BONES * MAT_WORDS);
  localparam int BW  = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LANE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [6:0]  bones_used_r;
  logic        reuse_r;
  logic [31:0] tally_r;
  logic        clr_r;
  logic [BW-1:0] clr_idx_r;

  logic [1:0]         op_r;
  logic signed [31:0] bind_r [3];
  logic signed [31:0] prev_r [3];
  logic [31:0]        ids_r;
  logic [63:0]        wts_r;

  logic [1:0]     j_r;
  logic [3:0]     wcnt_r;
  logic [SAW-1:0] base_r;
  logic [15:0]    lw_r;
  logic           needs_r;
  logic           any_r;
  logic [TOT_W-1:0] total_r;

  lbss_tag_t b_tag_r, c_tag_r, d_tag_r, rd_tag;
  logic signed [63:0] prod_r;
  logic signed [31:0] trans_r;
  logic signed [65:0] rowsum_r;
  logic signed [31:0] p_r;
  logic signed [ACC_W-1:0] acc_r [3];

  logic               out_vld_r;
  logic signed [31:0] out_c_r [3];
  logic               out_rec_r;
  logic [31:0]        out_cnt_r;
  logic               out_end_r;

  logic in_fire, out_fire, res_load, rd_en, div_start, pipe_empty, lane_last;
  logic [8:0]  limit;
  logic [7:0]  lid [LANES_CARRIED];
  logic [15:0] lwt [LANES_CARRIED];
  logic [LANES_CARRIED-1:0] lok;
  logic [11:0] id12, base12, ld12, laddr12;
  logic [8:0]  ld_bone;
  logic [3:0]  ld_entry;
  logic        st_we;
  logic [31:0] rdata;
  logic        mk_ld;
  logic        mk_we;
  logic [BW-1:0] mk_waddr;
  logic        mk_wdata;
  logic        mk_rdata;
  logic signed [31:0] src_sel;
  logic signed [66:0] pwide;
  logic signed [31:0] psat;
  logic [31:0] qv [3];
  logic [2:0]  div_done;
  logic signed [31:0] res_c [3];
  logic [31:0] cnt_new;

  assign in_stall  = (state_r != S_IDLE) || clr_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_vld_r && !out_stall;
  assign res_load  = (state_r == S_DONE) && (!out_vld_r || !out_stall);
  assign rd_en     = (state_r == S_READ);
  assign lane_last = (j_r == 2'(NL - 1));
  assign pipe_empty = !b_tag_r.vld && !c_tag_r.vld && !d_tag_r.vld;
  assign div_start = (state_r == S_DRAIN) && pipe_empty && needs_r && any_r;

  always_comb begin
    if (bones_used_r == 7'd0) begin
      limit = 9'd0;
    end else if (9'(bones_used_r) > 9'(MAX_BONES)) begin
      limit = 9'(MAX_BONES);
    end else begin
      limit = 9'(bones_used_r);
    end
    for (int l = 0; l < LANES_CARRIED; l++) begin
      lid[l] = ids_r[8*l +: 8];
      lwt[l] = wts_r[16*l +: 16];
      lok[l] = (l < NL) && ({1'b0, lid[l]} < limit) && !lwt[l][15] && (lwt[l] != 16'd0);
    end
  end

  assign id12    = 12'(lid[j_r]);
  assign base12  = (id12 << 3) + (id12 << 2);
  assign ld_bone = 9'(in_load_address[9:4]);
  assign ld_entry = in_load_address[3:0];
  assign ld12    = 12'(ld_bone);
  assign laddr12 = (ld12 << 3) + (ld12 << 2) + 12'(ld_entry);
  assign st_we   = in_fire && (in_opcode == OP_LOAD) && (ld_bone < 9'(MAX_BONES))
                   && (ld_entry < 4'(MAT_WORDS));
  assign mk_ld   = in_fire && (in_opcode == OP_LOAD) && (ld_bone < 9'(MAX_BONES))
                   && (ld_entry == 4'(MARK_ENTRY));
  assign mk_we    = clr_r || mk_ld;
  assign mk_waddr = clr_r ? clr_idx_r : ld_bone[BW-1:0];
  assign mk_wdata = !clr_r && in_load_value[0];

  lbss_ram #(.WIDTH(32), .DEPTH(MAX_BONES * MAT_WORDS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (laddr12[SAW-1:0]),
    .wdata (in_load_value),
    .raddr (base_r + SAW'(wcnt_r)),
    .rdata (rdata)
  );

  lbss_ram #(.WIDTH(1), .DEPTH(MAX_BONES)) u_marks (
    .clk   (clk),
    .we    (mk_we),
    .waddr (mk_waddr),
    .wdata (mk_wdata),
    .raddr (lid[j_r][BW-1:0]),
    .rdata (mk_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_opcode == OP_SKIN || in_opcode == OP_SKIN_LAST)) begin
          state_nxt = S_LANE;
        end
      end
      S_LANE: begin
        if (lok[j_r]) begin
          state_nxt = S_READ;
        end else if (lane_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_READ: begin
        if (wcnt_r == 4'(MAT_WORDS - 1)) begin
          state_nxt = lane_last ? S_DRAIN : S_LANE;
        end
      end
      S_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = (needs_r && any_r) ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        if (div_done[0]) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_tag     = '0;
    rd_tag.vld = rd_en;
    rd_tag.row = wcnt_r[3:2];
    rd_tag.k   = wcnt_r[1:0];
    rd_tag.w   = lw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bones_used_r <= 7'd1;
      reuse_r      <= 1'b0;
      tally_r      <= '0;
      clr_r        <= 1'b1;
      clr_idx_r    <= '0;
      out_vld_r    <= 1'b0;
      b_tag_r      <= '0;
      c_tag_r      <= '0;
      d_tag_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BONES_USED: bones_used_r <= cfg_wdata;
          CFG_REUSE:      reuse_r      <= cfg_wdata[0];
          default:        reuse_r      <= reuse_r;
        endcase
      end
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + BW'(1);
        if (clr_idx_r == BW'(MAX_BONES - 1)) begin
          clr_r <= 1'b0;
        end
      end
      b_tag_r <= rd_tag;
      c_tag_r <= b_tag_r;
      d_tag_r <= (c_tag_r.vld && c_tag_r.k == 2'd3) ? c_tag_r : '0;
      if (res_load) begin
        out_vld_r <= 1'b1;
        tally_r   <= (op_r == OP_SKIN_LAST) ? 32'd0 : cnt_new;
      end else if (out_fire) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign src_sel = (b_tag_r.k == 2'd0) ? bind_r[0] :
                   (b_tag_r.k == 2'd1) ? bind_r[1] : bind_r[2];
  assign pwide   = 67'(rowsum_r >>> 16) + 67'(trans_r);
  assign psat    = (pwide > 67'sd2147483647)  ? 32'sh7fffffff :
                   (pwide < -67'sd2147483648) ? 32'sh80000000 : 32'(pwide);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r      <= in_opcode;
      bind_r[0] <= in_bind_x;
      bind_r[1] <= in_bind_y;
      bind_r[2] <= in_bind_z;
      prev_r[0] <= in_prev_x;
      prev_r[1] <= in_prev_y;
      prev_r[2] <= in_prev_z;
      ids_r     <= in_bone_ids_packed;
      wts_r     <= in_weights_packed;
      j_r       <= 2'd0;
      needs_r   <= !reuse_r;
      any_r     <= 1'b0;
      total_r   <= '0;
      rowsum_r  <= '0;
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
    end else begin
      if (state_r == S_LANE) begin
        if (lok[j_r]) begin
          base_r  <= base12[SAW-1:0];
          wcnt_r  <= 4'd0;
          lw_r    <= lwt[j_r];
          any_r   <= 1'b1;
          total_r <= total_r + TOT_W'(lwt[j_r]);
        end else if (!lane_last) begin
          j_r <= j_r + 2'd1;
        end
      end
      if (rd_en) begin
        wcnt_r <= wcnt_r + 4'd1;
        if (wcnt_r == 4'd0 && mk_rdata) begin
          needs_r <= 1'b1;
        end
        if (wcnt_r == 4'(MAT_WORDS - 1) && !lane_last) begin
          j_r <= j_r + 2'd1;
        end
      end
      if (b_tag_r.vld) begin
        if (b_tag_r.k == 2'd3) begin
          trans_r <= rdata;
        end else begin
          prod_r <= $signed(rdata) * src_sel;
        end
      end
      if (c_tag_r.vld) begin
        if (c_tag_r.k == 2'd3) begin
          p_r      <= psat;
          rowsum_r <= '0;
        end else begin
          rowsum_r <= rowsum_r + 66'(prod_r);
        end
      end
      if (d_tag_r.vld) begin
        acc_r[d_tag_r.row] <= acc_r[d_tag_r.row] + ACC_W'(p_r * $signed(d_tag_r.w));
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    lbss_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (acc_r[c]),
      .divisor  (total_r),
      .quotient (qv[c]),
      .done     (div_done[c])
    );
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!needs_r) begin
        res_c[c] = prev_r[c];
      end else if (!any_r) begin
        res_c[c] = bind_r[c];
      end else begin
        res_c[c] = qv[c];
      end
    end
    cnt_new = needs_r ? (tally_r + 32'd1) : tally_r;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      for (int c = 0; c < 3; c++) begin
        out_c_r[c] <= res_c[c];
      end
      out_rec_r <= needs_r;
      out_cnt_r <= cnt_new;
      out_end_r <= (op_r == OP_SKIN_LAST);
    end
  end

  assign out_valid         = out_vld_r;
  assign out_x             = out_c_r[0];
  assign out_y             = out_c_r[1];
  assign out_z             = out_c_r[2];
  assign out_recomputed    = out_rec_r;
  assign out_updated_count = out_cnt_r;
  assign out_batch_end     = out_end_r;

`include "linear_blend_skinning_sparse_assert.svh"

  `LBSS_ASSERT_IMP(a_pipe_idle_in_div, state_r == S_DIV, pipe_empty, "fetch busy during divide")
  `LBSS_ASSERT_IMP(a_out_free, res_load, !out_vld_r || !out_stall, "result overwrites beat")
  `LBSS_ASSERT_IMP(a_div_sync, div_done[0], div_done[1] && div_done[2], "dividers out of step")
  `LBSS_ASSERT_NXT(a_tally_clear, res_load && op_r == OP_SKIN_LAST, tally_r == 32'd0, "tally kept")

endmodule

// ----- rtl/core/lbss_ram.sv -----
module lbss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- rtl/core/lbss_div.sv -----
module lbss_div import lbss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] dividend,
  input  logic [TOT_W-1:0]        divisor,
  output logic [31:0]             quotient,
  output logic                    done
);

  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic              neg_r;
  logic [TOT_W-1:0]  rem_r;
  logic [31:0]       dvd_r;
  logic [TOT_W-1:0]  dsr_r;
  logic [ACC_W-1:0]  mag;
  logic [TOT_W:0]    trial;
  logic              qbit;

  assign mag   = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
  assign trial = {rem_r, dvd_r[31]};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[ACC_W-1];
      rem_r <= {1'b0, mag[47:32]};
      dvd_r <= mag[31:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? TOT_W'(trial - {1'b0, dsr_r}) : trial[TOT_W-1:0];
      dvd_r <= {dvd_r[30:0], qbit};
    end
  end

  assign quotient = neg_r ? (32'd0 - dvd_r) : dvd_r;
  assign done     = done_r;

endmodule
